// ----- hdl/bpa_pkg.sv -----
// Shared constants for the bitmap page allocator.
package bpa_pkg;

  localparam int NUM_PAGES = 8192;
  localparam int WORD_W    = 32;
  localparam int ROWS      = NUM_PAGES / WORD_W;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int SUBS      = WORD_W / 8;
  localparam int SUB_W     = $clog2(SUBS);

  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_ALLOC = 3'd1;
  localparam logic [2:0] REQ_FREE  = 3'd2;
  localparam logic [2:0] REQ_MARK  = 3'd3;
  localparam logic [2:0] REQ_QUERY = 3'd4;
  localparam logic [2:0] REQ_STATS = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGE   = 2'd1;
  localparam logic [1:0] ST_PROTECTED = 2'd2;

  localparam logic       REG_KERNEL_END = 1'b0;
  localparam logic       REG_PROTECTED  = 1'b1;

endpackage

// ----- hdl/bitmap_page_allocator.sv -----
// Bitmap page allocator: used map in a 256 x 32 memory, walked by one sequencer.
//
//  channel  signals                                   word
//  in       in_valid / in_ready                       req_type, page_index
//  out      out_valid / out_ready                     status ... free_total
//  cfg      psel, penable, pwrite, paddr, pwdata      kernel_end_page, protected_pages
//
// One memory row of 32 pages is read per step through the single read port.
// init fills every row; alloc scans from row 0 to the first free bit; free, mark used, query
// read one row; stats walks rows in 8-page slices, then multiply and 24-step divide.
// After reset a clearing pass over all 256 rows runs before the first word is taken.
// A finished word waits in the output register; the next word is taken meanwhile.
module bitmap_page_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [12:0] page_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [12:0] alloc_page,
  output logic        page_used,
  output logic [13:0] user_used,
  output logic [13:0] user_free,
  output logic [13:0] longest_run,
  output logic [12:0] run_count,
  output logic [9:0]  frag_pm,
  output logic [31:0] alloc_total,
  output logic [31:0] free_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_AL_A  = 4'd3;
  localparam logic [3:0] S_AL_B  = 4'd4;
  localparam logic [3:0] S_RMW_W = 4'd5;
  localparam logic [3:0] S_RMW   = 4'd6;
  localparam logic [3:0] S_ST_W  = 4'd7;
  localparam logic [3:0] S_ST_P  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  localparam int ROW_W = bpa_pkg::ROW_W;

  logic [bpa_pkg::WORD_W-1:0] mem [bpa_pkg::ROWS];
  logic [bpa_pkg::WORD_W-1:0] rdata;
  logic                       mem_we;
  logic [bpa_pkg::WORD_W-1:0] mem_wdata;
  logic [ROW_W-1:0]           mem_waddr;

  logic [3:0]  state;
  logic [2:0]  req;
  logic [12:0] pg;
  logic [ROW_W-1:0] row, chk;
  logic [bpa_pkg::SUB_W-1:0] sub;
  logic [4:0]  cnt;
  logic [13:0] kend, prot, first;
  logic [31:0] alloc_counter, free_counter;
  logic [1:0]  st;
  logic [12:0] grant;
  logic        ubit;
  logic [13:0] run, lrun, used, sfree;
  logic [12:0] runs;
  logic [13:0] run_next, lrun_next, used_next;
  logic [12:0] runs_next;
  logic [23:0] prod;
  logic [13:0] rem;
  logic [14:0] trial;

  logic [13:0] top;
  logic [8:0]  trow;
  logic [bpa_pkg::WORD_W-1:0] fill_word;
  logic        zfound;
  logic [bpa_pkg::BIT_W-1:0] zidx;
  logic [7:0]  sbits;
  logic [13:0] ulimit;

  // register port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == bpa_pkg::REG_PROTECTED) begin
      prdata = {18'd0, prot};
    end else begin
      prdata = {18'd0, kend};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kend <= 14'd256;
      prot <= 14'd256;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bpa_pkg::REG_PROTECTED) begin
        prot <= pwdata[13:0];
      end else begin
        kend <= pwdata[13:0];
      end
    end
  end

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[row];
  end

  // init / clear row word
  always_comb begin
    top  = (state == S_CLEAR) ? 14'd0 :
           ((kend > 14'(bpa_pkg::NUM_PAGES)) ? 14'(bpa_pkg::NUM_PAGES) : kend);
    trow = top[13:5];
    if ({1'b0, row} < trow) begin
      fill_word = '1;
    end else if ({1'b0, row} == trow) begin
      fill_word = ~({bpa_pkg::WORD_W{1'b1}} << top[4:0]);
    end else begin
      fill_word = '0;
    end
  end

  // lowest free bit of the row being checked
  always_comb begin
    zfound = 1'b0;
    zidx   = '0;
    for (int k = bpa_pkg::WORD_W - 1; k >= 0; k--) begin
      if (!rdata[k]) begin
        zfound = 1'b1;
        zidx   = bpa_pkg::BIT_W'(k);
      end
    end
  end

  // eight pages of the stats walk
  always_comb begin
    sbits     = rdata[sub*8 +: 8];
    run_next  = run;
    lrun_next = lrun;
    used_next = used;
    runs_next = runs;
    for (int k = 0; k < 8; k++) begin
      if ({1'b0, row, sub, 3'(k)} >= first) begin
        if (!sbits[k]) begin
          run_next = run_next + 14'd1;
          if (run_next == 14'd1) begin
            runs_next = runs_next + 13'd1;
          end
          if (run_next > lrun_next) begin
            lrun_next = run_next;
          end
        end else begin
          used_next = used_next + 14'd1;
          run_next  = '0;
        end
      end
    end
  end

  assign ulimit = 14'(bpa_pkg::NUM_PAGES) - first;
  assign trial  = {rem, prod[23]};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row;
    mem_wdata = fill_word;
    unique case (state)
      S_CLEAR, S_INIT: begin
        mem_we = 1'b1;
      end
      S_AL_B: begin
        mem_waddr = chk;
        mem_wdata = rdata | (bpa_pkg::WORD_W'(1) << zidx);
        mem_we    = zfound;
      end
      S_RMW: begin
        if (req == bpa_pkg::REQ_FREE) begin
          mem_wdata = rdata & ~(bpa_pkg::WORD_W'(1) << pg[4:0]);
          mem_we    = (st == bpa_pkg::ST_OK);
        end else begin
          mem_wdata = rdata | (bpa_pkg::WORD_W'(1) << pg[4:0]);
          mem_we    = (req == bpa_pkg::REQ_MARK);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      row           <= '0;
      out_valid     <= 1'b0;
      alloc_counter <= '0;
      free_counter  <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          row <= row + 1'b1;
          if (row == ROW_W'(bpa_pkg::ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= req_type;
            pg    <= page_index;
            st    <= bpa_pkg::ST_OK;
            grant <= '0;
            ubit  <= 1'b0;
            sub   <= '0;
            run   <= '0;
            lrun  <= '0;
            used  <= '0;
            runs  <= '0;
            sfree <= '0;
            first <= (prot > 14'(bpa_pkg::NUM_PAGES)) ? 14'(bpa_pkg::NUM_PAGES) : prot;
            unique case (req_type)
              bpa_pkg::REQ_INIT: begin
                row   <= '0;
                state <= S_INIT;
              end
              bpa_pkg::REQ_ALLOC: begin
                alloc_counter <= alloc_counter + 32'd1;
                row           <= '0;
                state         <= S_AL_A;
              end
              bpa_pkg::REQ_FREE, bpa_pkg::REQ_MARK, bpa_pkg::REQ_QUERY: begin
                row   <= page_index[12:5];
                state <= S_RMW_W;
              end
              bpa_pkg::REQ_STATS: begin
                row   <= '0;
                state <= S_ST_W;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_INIT: begin
          row <= row + 1'b1;
          if (row == ROW_W'(bpa_pkg::ROWS - 1)) begin
            state <= S_FIN;
          end
        end
        S_AL_A: begin
          chk   <= row;
          row   <= row + 1'b1;
          state <= S_AL_B;
        end
        S_AL_B: begin
          if (zfound) begin
            grant <= {chk, zidx};
            state <= S_FIN;
          end else if (chk == ROW_W'(bpa_pkg::ROWS - 1)) begin
            st    <= bpa_pkg::ST_NO_PAGE;
            state <= S_FIN;
          end else begin
            chk <= row;
            row <= row + 1'b1;
          end
        end
        S_RMW_W: begin
          if (req == bpa_pkg::REQ_FREE && {1'b0, pg} < prot) begin
            st <= bpa_pkg::ST_PROTECTED;
          end
          state <= S_RMW;
        end
        S_RMW: begin
          ubit <= (req == bpa_pkg::REQ_QUERY) && rdata[pg[4:0]];
          if (req == bpa_pkg::REQ_FREE && st == bpa_pkg::ST_OK) begin
            free_counter <= free_counter + 32'd1;
          end
          state <= S_FIN;
        end
        S_ST_W: begin
          state <= S_ST_P;
        end
        S_ST_P: begin
          run  <= run_next;
          lrun <= lrun_next;
          used <= used_next;
          runs <= runs_next;
          sub  <= sub + 1'b1;
          if (sub == bpa_pkg::SUB_W'(bpa_pkg::SUBS - 1)) begin
            if (row == ROW_W'(bpa_pkg::ROWS - 1)) begin
              state <= S_MUL;
            end else begin
              row   <= row + 1'b1;
              state <= S_ST_W;
            end
          end
        end
        S_MUL: begin
          sfree <= ulimit - used;
          prod  <= 24'(lrun) * 24'd1000;
          rem   <= '0;
          cnt   <= '0;
          state <= (ulimit == used) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, sfree}) begin
            rem  <= 14'(trial - {1'b0, sfree});
            prod <= {prod[22:0], 1'b1};
          end else begin
            rem  <= trial[13:0];
            prod <= {prod[22:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd23) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= st;
            alloc_page  <= grant;
            page_used   <= ubit;
            user_used   <= used;
            user_free   <= sfree;
            longest_run <= lrun;
            run_count   <= runs;
            frag_pm     <= (sfree == 14'd0) ? 10'd0 : 10'd1000 - prod[9:0];
            alloc_total <= alloc_counter;
            free_total  <= free_counter;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
